FILE: design/stl_pkg.sv
// shared types, constants and helper functions for the script token lexer
// no dependencies; imported by stl_core, stl_token_queue and script_token_lexer
package stl_pkg;

  // token kinds above the single-byte range
  localparam logic [8:0] KIND_IF      = 9'd256;
  localparam logic [8:0] KIND_ELSE    = 9'd257;
  localparam logic [8:0] KIND_BUILD   = 9'd258;
  localparam logic [8:0] KIND_PROJECT = 9'd259;
  localparam logic [8:0] KIND_RUN     = 9'd260;
  localparam logic [8:0] KIND_FOR     = 9'd261;
  localparam logic [8:0] KIND_WHILE   = 9'd262;
  localparam logic [8:0] KIND_IN      = 9'd263;
  localparam logic [8:0] KIND_AND     = 9'd264;
  localparam logic [8:0] KIND_OR      = 9'd265;
  localparam logic [8:0] KIND_EQ      = 9'd266;
  localparam logic [8:0] KIND_NEQ     = 9'd267;
  localparam logic [8:0] KIND_END     = 9'd268;
  localparam logic [8:0] KIND_IDENT   = 9'd269;
  localparam logic [8:0] KIND_INT     = 9'd270;
  localparam logic [8:0] KIND_STR     = 9'd271;
  localparam logic [8:0] KIND_BOOL    = 9'd272;

  // special characters
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_LBRACE = 8'h7b;
  localparam logic [7:0] CH_RBRACE = 8'h7d;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PIPE  = 8'h7c;
  localparam logic [7:0] CH_EQUAL = 8'h3d;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_FF    = 8'h0c;
  localparam logic [7:0] CH_CR    = 8'h0d;

  // word prefixes, first byte in the low bits
  localparam logic [55:0] W_IF      = 56'h00000000006669;
  localparam logic [55:0] W_ELSE    = 56'h00000065736c65;
  localparam logic [55:0] W_BUILD   = 56'h0000646c697562;
  localparam logic [55:0] W_PROJECT = 56'h7463656a6f7270;
  localparam logic [55:0] W_RUN     = 56'h000000006e7572;
  localparam logic [55:0] W_FOR     = 56'h00000000726f66;
  localparam logic [55:0] W_WHILE   = 56'h0000656c696877;
  localparam logic [55:0] W_IN      = 56'h00000000006e69;
  localparam logic [55:0] W_TRUE    = 56'h00000065757274;
  localparam logic [55:0] W_FALSE   = 56'h000065736c6166;

  // result queue depth
  localparam int QDEPTH = 4;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [8:0]  token_kind;
    logic [23:0] start_offset;
    logic [15:0] token_length;
    logic [23:0] line_number;
    logic [15:0] column_number;
    logic        format_string;
    logic        last_of_run;
  } token_t;

  // tokens produced by one lexer step
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } step_out_t;

  typedef struct packed {
    logic [$clog2(QDEPTH):0] count;
    logic                    room2;
  } q_status_t;

  function automatic logic is_digit(logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a));
  endfunction

  function automatic logic is_alnum(logic [7:0] c);
    return is_digit(c) || is_alpha(c);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0d)) || (c == 8'h00);
  endfunction

  function automatic logic [15:0] sat16_inc(logic [15:0] v);
    return (v != 16'hffff) ? v + 16'd1 : v;
  endfunction

  // keyword / bool / identifier classification of a finished word
  function automatic logic [8:0] word_kind(logic [55:0] prefix, logic [15:0] len);
    logic [8:0] k;
    k = KIND_IDENT;
    if (len == 16'd2 && prefix == W_IF) k = KIND_IF;
    else if (len == 16'd4 && prefix == W_ELSE) k = KIND_ELSE;
    else if (len == 16'd5 && prefix == W_BUILD) k = KIND_BUILD;
    else if (len == 16'd7 && prefix == W_PROJECT) k = KIND_PROJECT;
    else if (len == 16'd3 && prefix == W_RUN) k = KIND_RUN;
    else if (len == 16'd3 && prefix == W_FOR) k = KIND_FOR;
    else if (len == 16'd5 && prefix == W_WHILE) k = KIND_WHILE;
    else if (len == 16'd2 && prefix == W_IN) k = KIND_IN;
    else if (len == 16'd4 && prefix == W_TRUE) k = KIND_BOOL;
    else if (len == 16'd5 && prefix == W_FALSE) k = KIND_BOOL;
    return k;
  endfunction

  function automatic token_t make_tok(logic [8:0] kind, logic [23:0] start,
                                      logic [15:0] len, logic [23:0] line,
                                      logic [15:0] col, logic fmt);
    token_t t;
    t.token_kind    = kind;
    t.start_offset  = start;
    t.token_length  = len;
    t.line_number   = line;
    t.column_number = col;
    t.format_string = fmt;
    t.last_of_run   = 1'b0;
    return t;
  endfunction

endpackage

FILE: design/stl_core.sv
// lexer state registers and the single-step next-state / token logic
// depends on stl_pkg
module stl_core #(
  parameter int MAX_BRACE_DEPTH = 255
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step_en,
  input  stl_pkg::in_item_t  item,
  output stl_pkg::step_out_t step_out
);
  import stl_pkg::*;

  localparam int BDW = $clog2(MAX_BRACE_DEPTH + 1);
  localparam logic [BDW-1:0] DEPTH_MAX = BDW'(MAX_BRACE_DEPTH);

  typedef enum logic [2:0] {
    M_IDLE, M_SLASH, M_COMMENT, M_STRING, M_BRACE, M_INT, M_IDENT, M_OP
  } mode_t;

  mode_t          mode_r, mode_nxt;
  logic [23:0]    token_start_r, token_start_nxt;
  logic [15:0]    token_len_r, token_len_nxt;
  logic [23:0]    byte_offset_r, byte_offset_nxt;
  logic [23:0]    cur_line_r, cur_line_nxt;
  logic [15:0]    cur_col_r, cur_col_nxt;
  logic [23:0]    start_line_r, start_line_nxt;
  logic [15:0]    start_col_r, start_col_nxt;
  logic [55:0]    prefix_r, prefix_nxt;
  logic [BDW-1:0] depth_r, depth_nxt;
  logic           fmt_r, fmt_nxt;
  logic           open_r, open_nxt;
  logic           tilde_r, tilde_nxt;

  token_t     toks [2];
  logic [1:0] n;
  logic       do_idle;
  logic       flush_vld;
  token_t     flush_tok;
  logic [8:0] op_kind;
  logic [7:0] c;

  // pending token flushed when a word, number or operator ends
  always_comb begin
    flush_vld = 1'b0;
    flush_tok = make_tok(KIND_INT, token_start_r, token_len_r, start_line_r,
                         start_col_r, 1'b0);
    case (mode_r)
      M_INT: begin
        flush_vld = 1'b1;
      end
      M_IDENT: begin
        flush_vld = 1'b1;
        flush_tok.token_kind = (token_len_r > 16'd7) ? KIND_IDENT :
                               word_kind(prefix_r, token_len_r);
      end
      M_OP, M_SLASH: begin
        flush_vld = 1'b1;
        flush_tok.token_kind = {1'b0, prefix_r[7:0]};
        flush_tok.token_length = 16'd1;
      end
      default: begin
        flush_vld = 1'b0;
      end
    endcase
  end

  always_comb begin
    c = item.in_byte;
    mode_nxt        = mode_r;
    token_start_nxt = token_start_r;
    token_len_nxt   = token_len_r;
    byte_offset_nxt = byte_offset_r;
    cur_line_nxt    = cur_line_r;
    cur_col_nxt     = cur_col_r;
    start_line_nxt  = start_line_r;
    start_col_nxt   = start_col_r;
    prefix_nxt      = prefix_r;
    depth_nxt       = depth_r;
    fmt_nxt         = fmt_r;
    open_nxt        = open_r;
    tilde_nxt       = tilde_r;
    toks[0] = '0;
    toks[1] = '0;
    n       = 2'd0;
    do_idle = 1'b0;
    op_kind = 9'd0;

    if (item.end_of_input) begin
      if (flush_vld) begin
        toks[n[0]] = flush_tok;
        n = n + 2'd1;
      end
      toks[n[0]] = make_tok(KIND_END, byte_offset_r, 16'd0, cur_line_r, cur_col_r, 1'b0);
      n = n + 2'd1;
      mode_nxt        = M_IDLE;
      token_start_nxt = '0;
      token_len_nxt   = '0;
      byte_offset_nxt = '0;
      cur_line_nxt    = 24'd1;
      cur_col_nxt     = 16'd1;
      start_line_nxt  = 24'd1;
      start_col_nxt   = 16'd1;
      prefix_nxt      = '0;
      depth_nxt       = '0;
      fmt_nxt         = 1'b0;
      open_nxt        = 1'b0;
      tilde_nxt       = 1'b0;
    end else begin
      case (mode_r)
        M_STRING: begin
          token_len_nxt = sat16_inc(token_len_r);
          if (tilde_r && c == CH_QUOTE) begin
            tilde_nxt = 1'b0;  // escaped quote stays in the string
          end else begin
            tilde_nxt = 1'b0;
            if (c == CH_QUOTE) begin
              toks[n[0]] = make_tok(KIND_STR, token_start_r, token_len_nxt,
                                    start_line_r, start_col_r, fmt_r);
              n = n + 2'd1;
              mode_nxt = M_IDLE;
            end else if (c == CH_TILDE) begin
              tilde_nxt = 1'b1;
            end else if (c == CH_LBRACE) begin
              fmt_nxt   = 1'b1;
              open_nxt  = 1'b1;
              depth_nxt = BDW'(1);
              mode_nxt  = M_BRACE;
            end
          end
        end
        M_BRACE: begin
          token_len_nxt = sat16_inc(token_len_r);
          if (c == CH_RBRACE) begin
            if (depth_r != '0) depth_nxt = depth_r - BDW'(1);
            open_nxt = 1'b0;
            if (depth_r <= BDW'(1)) mode_nxt = M_STRING;
          end else if (c == CH_LBRACE) begin
            if (open_r) fmt_nxt = 1'b0;  // doubled brace is a literal brace
            if (depth_r < DEPTH_MAX) depth_nxt = depth_r + BDW'(1);
            open_nxt = 1'b1;
          end else begin
            open_nxt = 1'b0;
          end
        end
        M_COMMENT: begin
          if (c == CH_LF) mode_nxt = M_IDLE;
        end
        M_INT: begin
          if (is_digit(c)) begin
            token_len_nxt = sat16_inc(token_len_r);
          end else begin
            toks[n[0]] = flush_tok;
            n = n + 2'd1;
            mode_nxt = M_IDLE;
            do_idle = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alnum(c)) begin
            if (token_len_r < 16'd7) prefix_nxt[{token_len_r[2:0], 3'b000} +: 8] = c;
            token_len_nxt = sat16_inc(token_len_r);
          end else begin
            toks[n[0]] = flush_tok;
            n = n + 2'd1;
            mode_nxt = M_IDLE;
            do_idle = 1'b1;
          end
        end
        M_OP: begin
          if (prefix_r[7:0] == CH_AMP && c == CH_AMP) op_kind = KIND_AND;
          else if (prefix_r[7:0] == CH_PIPE && c == CH_PIPE) op_kind = KIND_OR;
          else if (prefix_r[7:0] == CH_EQUAL && c == CH_EQUAL) op_kind = KIND_EQ;
          else if (prefix_r[7:0] == CH_BANG && c == CH_EQUAL) op_kind = KIND_NEQ;
          if (op_kind != 9'd0) begin
            toks[n[0]] = make_tok(op_kind, token_start_r, 16'd2, start_line_r,
                                  start_col_r, 1'b0);
            n = n + 2'd1;
            mode_nxt = M_IDLE;
          end else begin
            toks[n[0]] = flush_tok;
            n = n + 2'd1;
            mode_nxt = M_IDLE;
            do_idle = 1'b1;
          end
        end
        M_SLASH: begin
          if (c == CH_SLASH) begin
            mode_nxt = M_COMMENT;
          end else begin
            toks[n[0]] = flush_tok;
            n = n + 2'd1;
            mode_nxt = M_IDLE;
            do_idle = 1'b1;
          end
        end
        default: begin
          mode_nxt = M_IDLE;
          do_idle = 1'b1;
        end
      endcase

      // byte not consumed by a pending token starts a new one, or is emitted at once as a single-byte token
      if (do_idle && !is_space(c)) begin
        if (c == CH_QUOTE || is_digit(c) || is_alpha(c) || c == CH_AMP ||
            c == CH_PIPE || c == CH_EQUAL || c == CH_BANG || c == CH_SLASH) begin
          token_start_nxt = byte_offset_r;
          start_line_nxt  = cur_line_r;
          start_col_nxt   = cur_col_r;
          token_len_nxt   = 16'd1;
          prefix_nxt      = {48'd0, c};
          if (c == CH_QUOTE) begin
            mode_nxt  = M_STRING;
            fmt_nxt   = 1'b0;
            open_nxt  = 1'b0;
            tilde_nxt = 1'b0;
          end else if (is_digit(c)) begin
            mode_nxt = M_INT;
          end else if (is_alpha(c)) begin
            mode_nxt = M_IDENT;
          end else if (c == CH_SLASH) begin
            mode_nxt = M_SLASH;
          end else begin
            mode_nxt = M_OP;
          end
        end else begin
          toks[n[0]] = make_tok({1'b0, c}, byte_offset_r, 16'd1, cur_line_r,
                                cur_col_r, 1'b0);
          n = n + 2'd1;
        end
      end

      // position tracking
      byte_offset_nxt = byte_offset_r + 24'd1;
      if (c == CH_LF) begin
        if (cur_line_r != 24'hffffff) cur_line_nxt = cur_line_r + 24'd1;
        cur_col_nxt = 16'd1;
      end else if (c != CH_FF && c != CH_CR) begin
        cur_col_nxt = sat16_inc(cur_col_r);
      end
    end

    if (n != 2'd0) toks[n[0] ^ 1'b1].last_of_run = 1'b1;

    step_out.count = step_en ? n : 2'd0;
    step_out.tok0  = toks[0];
    step_out.tok1  = toks[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= M_IDLE;
      token_start_r <= '0;
      token_len_r   <= '0;
      byte_offset_r <= '0;
      cur_line_r    <= 24'd1;
      cur_col_r     <= 16'd1;
      start_line_r  <= 24'd1;
      start_col_r   <= 16'd1;
      prefix_r      <= '0;
      depth_r       <= '0;
      fmt_r         <= 1'b0;
      open_r        <= 1'b0;
      tilde_r       <= 1'b0;
    end else if (step_en) begin
      mode_r        <= mode_nxt;
      token_start_r <= token_start_nxt;
      token_len_r   <= token_len_nxt;
      byte_offset_r <= byte_offset_nxt;
      cur_line_r    <= cur_line_nxt;
      cur_col_r     <= cur_col_nxt;
      start_line_r  <= start_line_nxt;
      start_col_r   <= start_col_nxt;
      prefix_r      <= prefix_nxt;
      depth_r       <= depth_nxt;
      fmt_r         <= fmt_nxt;
      open_r        <= open_nxt;
      tilde_r       <= tilde_nxt;
    end
  end

endmodule

FILE: design/stl_token_queue.sv
// small result queue: takes up to two tokens a cycle, hands out one while out_stall is low
// depends on stl_pkg
module stl_token_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  stl_pkg::step_out_t wr,
  input  logic               out_stall,
  output logic               out_valid,
  output stl_pkg::token_t    head,
  output stl_pkg::q_status_t status
);
  import stl_pkg::*;

  localparam int QAW = $clog2(QDEPTH);

  token_t         mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;
  logic           pop;

  assign out_valid = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];
  assign pop       = out_valid && !out_stall;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + QAW'(wr.count);
    rd_ptr_nxt = pop ? rd_ptr_r + QAW'(1) : rd_ptr_r;
    count_nxt  = count_r + (QAW+1)'(wr.count) - (QAW+1)'(pop);
  end

  assign status.count = count_r;
  assign status.room2 = (count_r <= (QAW+1)'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.count != 2'd0) mem_r[wr_ptr_r] <= wr.tok0;
    if (wr.count == 2'd2) mem_r[wr_ptr_r + QAW'(1)] <= wr.tok1;
  end

endmodule

FILE: design/script_token_lexer.sv
// streaming source lexer, top level: lexer step plus result queue
// depends on stl_pkg, stl_core, stl_token_queue
//
// usage
//   input channel (in_valid / in_stall / in_item): one source byte per item,
//   or an end-of-input marker with end_of_input set. an item is taken on a
//   rising edge with in_valid high and in_stall low.
//   result channel (out_valid / out_stall / out_item): one token per item,
//   with kind, start offset, length, line, column and the format flag.
//   last_of_run marks the final token caused by one input item.
// timing
//   the lexer state advances on the edge that takes the item; its tokens
//   (zero, one or two) land in a four-entry queue on that same edge and
//   show on the result port once the tokens ahead of them have left.
//   throughput is one input item per cycle while in_stall is low; the output
//   port moves one token per cycle while out_stall is low, bounding two-token items.
//   in_stall rises only when the queue cannot take two more tokens.
// reset
//   synchronous active-low rst_n empties the queue and returns the lexer to
//   idle at offset 0, line 1, column 1. an end-of-input item does the same
//   to the lexer after its end token.
// stall
//   a stalled result holds its token; input items are taken while two entries are free
module script_token_lexer #(
  parameter int MAX_BRACE_DEPTH = 255
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  stl_pkg::in_item_t in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output stl_pkg::token_t   out_item
);
  import stl_pkg::*;

  step_out_t step_out;
  q_status_t q_stat;
  logic      in_accept;

  // accept whenever the queue has room for a worst-case item
  assign in_stall  = !q_stat.room2;
  assign in_accept = in_valid && !in_stall;

  // lexer step: state registers and next-token logic
  stl_core #(
    .MAX_BRACE_DEPTH(MAX_BRACE_DEPTH)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .step_en  (in_accept),
    .item     (in_item),
    .step_out (step_out)
  );

  // result queue decouples the two handshakes
  stl_token_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (step_out),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .head      (out_item),
    .status    (q_stat)
  );

  // end of input always produces a trailing end token
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_item.end_of_input) |->
      ((step_out.count == 2'd1 && step_out.tok0.token_kind == KIND_END) ||
       (step_out.count == 2'd2 && step_out.tok1.token_kind == KIND_END)))
    else $error("end of input without end token");

  // only the final token of a step carries last_of_run
  assert property (@(posedge clk) disable iff (!rst_n)
    (step_out.count == 2'd2) |->
      (!step_out.tok0.last_of_run && step_out.tok1.last_of_run))
    else $error("last_of_run misplaced on two-token step");

  // queue never exceeds its depth
  assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= ($clog2(QDEPTH)+1)'(QDEPTH))
    else $error("result queue overflow");

  // a step that produced tokens leaves the queue non-empty next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    (step_out.count != 2'd0) |=> out_valid)
    else $error("tokens lost in queue");

endmodule
